// ===== sv/int_to_ascii_digits_assert.svh =====
// Assertion macros for the int_to_ascii_digits block.
// Included by the top level only; no other dependencies.
`ifndef INT_TO_ASCII_DIGITS_ASSERT_SVH
`define INT_TO_ASCII_DIGITS_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define ITA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, off while reset is held.
`define ITA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication that is also checked across reset.
`define ITA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== sv/ita_pkg.sv =====
// Shared types, constants and helper functions for int_to_ascii_digits.
// No dependencies; imported by every module of the block.
package ita_pkg;

    localparam int ValueW        = 32;
    localparam int DigitW        = 4;
    localparam int NumDigits     = 10;
    localparam int NumHexDigits  = ValueW / DigitW;
    localparam int BcdW          = NumDigits * DigitW;
    localparam int PosW          = $clog2(NumDigits);
    localparam int StepsPerStage = 4;
    localparam int NumStages     = ValueW / StepsPerStage;
    localparam int CharW         = 8;

    localparam logic [PosW-1:0]   MaxDecWidth = PosW'(NumDigits);
    localparam logic [PosW-1:0]   MaxHexWidth = PosW'(NumHexDigits);
    localparam logic [CharW-1:0]  AsciiZero   = 8'h30;
    localparam logic [CharW-1:0]  AsciiUpperA = 8'h41;
    localparam logic [DigitW-1:0] DecBase     = 4'd10;
    localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
    localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

    typedef enum logic {
        RADIX_DEC = 1'b0,
        RADIX_HEX = 1'b1
    } radix_t;

    typedef enum logic [1:0] {
        REG_RADIX_MODE  = 2'd0,
        REG_DIGIT_COUNT = 2'd1,
        REG_FILL_CHAR   = 2'd2
    } reg_index_t;

    typedef struct packed {
        radix_t           radix_mode;
        logic [PosW-1:0]  digit_count;
        logic [CharW-1:0] fill_char;
    } cfg_t;

    // One item moving through the binary-to-BCD pipeline.
    typedef struct packed {
        logic [BcdW-1:0]   bcd;
        logic [ValueW-1:0] bin;
        logic [ValueW-1:0] raw;
    } work_t;

    // StepsPerStage shift-and-add-3 steps on one item.
    function automatic work_t dabble_steps(work_t w);
        work_t r;
        r = w;
        for (int s = 0; s < StepsPerStage; s++) begin
            for (int d = 0; d < NumDigits; d++) begin
                if (r.bcd[d*DigitW +: DigitW] >= DabbleLimit) begin
                    r.bcd[d*DigitW +: DigitW] = r.bcd[d*DigitW +: DigitW] + DabbleAdd;
                end
            end
            r.bcd = {r.bcd[BcdW-2:0], r.bin[ValueW-1]};
            r.bin = {r.bin[ValueW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [CharW-1:0] digit_to_ascii(logic [DigitW-1:0] d);
        logic [CharW-1:0] c;
        if (d < DecBase) begin
            c = AsciiZero + CharW'(d);
        end else begin
            c = AsciiUpperA + CharW'(d - DecBase);
        end
        return c;
    endfunction

endpackage

// ===== sv/ita_dabble_stage.sv =====
// One register stage of the binary-to-BCD pipeline.
// Depends on ita_pkg for work_t and dabble_steps.
module ita_dabble_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ita_pkg::work_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ita_pkg::work_t out_data
);
    import ita_pkg::*;

    logic  valid_reg;
    work_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= dabble_steps(in_data);
        end
    end

endmodule

// ===== sv/ita_serializer.sv =====
// Turns one converted value into a stream of characters, most significant first,
// with leading-zero fill and the width check. Depends on ita_pkg.
module ita_serializer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ita_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ita_pkg::work_t            in_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ita_pkg::CharW-1:0] m_char_code,
    output logic                      m_last_char,
    output logic                      m_bad_width
);
    import ita_pkg::*;

    logic                              busy_reg;
    logic [NumDigits-1:0][DigitW-1:0]  digits_reg;
    logic [PosW-1:0]                   pos_reg;
    logic                              leading_reg;
    logic                              bad_reg;

    logic                              out_valid_reg;
    logic [CharW-1:0]                  char_reg;
    logic                              last_reg;
    logic                              badw_reg;

    logic                              emit;
    logic                              load;
    logic                              is_last;
    logic                              bad_next;
    logic [DigitW-1:0]                 cur_digit;
    logic                              use_fill;
    logic [CharW-1:0]                  char_next;
    logic [NumDigits-1:0][DigitW-1:0]  digits_next;

    assign emit      = busy_reg && (!out_valid_reg || m_ready);
    assign is_last   = (pos_reg == '0);
    assign in_ready  = !busy_reg || (emit && is_last);
    assign load      = in_valid && in_ready;
    assign cur_digit = digits_reg[pos_reg];
    assign use_fill  = leading_reg && (cur_digit == '0) && !is_last;

    always_comb begin
        if (bad_reg) begin
            char_next = '0;
        end else if (use_fill) begin
            char_next = cfg.fill_char;
        end else begin
            char_next = digit_to_ascii(cur_digit);
        end
    end

    always_comb begin
        if (cfg.radix_mode == RADIX_HEX) begin
            bad_next    = (cfg.digit_count == '0) || (cfg.digit_count > MaxHexWidth);
            digits_next = {{(BcdW-ValueW){1'b0}}, in_data.raw};
        end else begin
            bad_next    = (cfg.digit_count == '0) || (cfg.digit_count > MaxDecWidth);
            digits_next = in_data.bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
            end else if (emit && is_last) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg  <= digits_next;
            bad_reg     <= bad_next;
            leading_reg <= 1'b1;
            pos_reg     <= bad_next ? '0 : cfg.digit_count - PosW'(1);
        end else if (emit) begin
            // drop the fill once the first significant digit has gone out
            if (!use_fill) begin
                leading_reg <= 1'b0;
            end
            if (!is_last) begin
                pos_reg <= pos_reg - PosW'(1);
            end
        end
        if (emit) begin
            char_reg <= char_next;
            last_reg <= is_last;
            badw_reg <= bad_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;
    assign m_bad_width = badw_reg;

endmodule

// ===== sv/int_to_ascii_digits.sv =====
// Top level of int_to_ascii_digits: configuration registers, BCD pipeline, serializer.
// Depends on ita_pkg, ita_dabble_stage, ita_serializer and int_to_ascii_digits_assert.svh.
//
// Usage:
//   s_valid/s_ready/s_value carries one 32-bit unsigned value per transaction.
//   m_valid/m_ready carries one character per transaction: m_char_code, with
//   m_last_char on the final character of a value and m_bad_width when the
//   digit count does not suit the radix (then a single transaction, code 0).
//   The APB port holds radix_mode (0x0), digit_count (0x4) and fill_char (0x8);
//   write it only while no value is in flight.
// Path: the first character of a value is presented after 8 binary-to-BCD
//   stages of 4 shift steps each, then the serializer load and its output
//   register.
// Throughput: a value gives digit_count characters (1 on a width error); the
//   serializer puts out one character per cycle while m_ready is high; the
//   pipeline queues up to 8 further values behind it.
// Reset: synchronous, active low; empties the pipeline and the output register
//   and restores decimal, 10 digits, fill 0x20.
// Stall: a low m_ready holds the current character; the serializer and the
//   pipeline back up in turn and s_ready drops once all stages are full.
module int_to_ascii_digits (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_code,
    output logic        m_last_char,
    output logic        m_bad_width,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ita_pkg::*;

    radix_t           radix_mode_reg;
    logic [PosW-1:0]  digit_count_reg;
    logic [CharW-1:0] fill_char_reg;
    reg_index_t       reg_idx;
    logic             cfg_write;
    cfg_t             cfg;

    logic  [NumStages:0] pipe_valid;
    logic  [NumStages:0] pipe_ready;
    work_t               pipe_data [NumStages+1];

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_mode_reg  <= RADIX_DEC;
            digit_count_reg <= 4'd10;
            fill_char_reg   <= 8'h20;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_RADIX_MODE:  radix_mode_reg  <= radix_t'(pwdata[0]);
                REG_DIGIT_COUNT: digit_count_reg <= pwdata[PosW-1:0];
                REG_FILL_CHAR:   fill_char_reg   <= pwdata[CharW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RADIX_MODE:  prdata = {31'b0, radix_mode_reg};
            REG_DIGIT_COUNT: prdata = {{(32-PosW){1'b0}}, digit_count_reg};
            REG_FILL_CHAR:   prdata = {{(32-CharW){1'b0}}, fill_char_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.radix_mode  = radix_mode_reg;
    assign cfg.digit_count = digit_count_reg;
    assign cfg.fill_char   = fill_char_reg;

    assign pipe_valid[0]    = s_valid;
    assign s_ready          = pipe_ready[0];
    assign pipe_data[0].bcd = '0;
    assign pipe_data[0].bin = s_value;
    assign pipe_data[0].raw = s_value;

    for (genvar g = 0; g < NumStages; g++) begin : g_stage
        ita_dabble_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (pipe_valid[g]),
            .in_ready (pipe_ready[g]),
            .in_data  (pipe_data[g]),
            .out_valid(pipe_valid[g+1]),
            .out_ready(pipe_ready[g+1]),
            .out_data (pipe_data[g+1])
        );
    end

    ita_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (pipe_valid[NumStages]),
        .in_ready   (pipe_ready[NumStages]),
        .in_data    (pipe_data[NumStages]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_code(m_char_code),
        .m_last_char(m_last_char),
        .m_bad_width(m_bad_width)
    );

`include "int_to_ascii_digits_assert.svh"

    `ITA_ASSERT_IMPL(a_bad_is_single, aclk, aresetn, m_valid && m_bad_width, m_last_char && (m_char_code == 8'h00))
    `ITA_ASSERT_NEXT(a_chars_contiguous, aclk, aresetn, m_valid && m_ready && !m_last_char, m_valid)
    `ITA_ASSERT_NEXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_valid && s_ready)

endmodule

// ===== bench/int_to_ascii_digits_tb.sv =====
// Self-checking testbench for int_to_ascii_digits: APB format setup, value stream in,
// per-character compare against an in-bench renderer. Depends on ita_pkg and the RTL.
module int_to_ascii_digits_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ita_pkg::*;

    localparam logic [7:0] CHAR_ZERO    = "0";
    localparam logic [7:0] CHAR_UPPER_A = "A";
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         SETTLE       = 12;
    localparam int         MAX_PRINTS   = 50;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       bad;
    } char_result_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_char_code;
    logic        m_last_char;
    logic        m_bad_width;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Format currently programmed into the block
    radix_t      cfg_radix  = RADIX_DEC;
    logic [3:0]  cfg_digits = 4'd10;
    logic [7:0]  cfg_fill   = 8'd32;

    logic [31:0]  pending_values[$];
    char_result_t expected_chars[$];
    int           error_count  = 0;
    int           idle_cycles  = 0;
    int           send_gap     = 0;
    int           take_gap     = 0;
    int           hold_left    = 0;
    bit           hold_request = 1'b0;
    bit           gaps_on      = 1'b1;

    int_to_ascii_digits u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_code(m_char_code),
        .m_last_char(m_last_char),
        .m_bad_width(m_bad_width),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // Render one value into the characters the block must emit.
    function automatic void render_value(input logic [31:0] value);
        logic [7:0]   text[10];
        logic [31:0]  rest;
        logic [31:0]  digit;
        int unsigned  base;
        int unsigned  widest;
        int unsigned  n;
        bit           leading;
        char_result_t res;
        base   = (cfg_radix == RADIX_HEX) ? 16 : 10;
        widest = (cfg_radix == RADIX_HEX) ? 8 : 10;
        n      = cfg_digits;
        if (n < 1 || n > widest) begin
            res.code = 8'h00;
            res.last = 1'b1;
            res.bad  = 1'b1;
            expected_chars.push_back(res);
            return;
        end
        rest = value;
        for (int i = int'(n) - 1; i >= 0; i--) begin
            digit = rest % base;
            rest  = rest / base;
            text[i] = (digit < 10) ? CHAR_ZERO + digit[7:0] : CHAR_UPPER_A + digit[7:0] - 8'd10;
        end
        // the final position is never replaced by the fill
        leading = 1'b1;
        for (int i = 0; i < int'(n) - 1; i++) begin
            if (leading && text[i] == CHAR_ZERO) begin
                text[i] = cfg_fill;
            end else begin
                leading = 1'b0;
            end
        end
        for (int i = 0; i < int'(n); i++) begin
            res.code = text[i];
            res.last = (i == int'(n) - 1);
            res.bad  = 1'b0;
            expected_chars.push_back(res);
        end
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIX_MODE:  cfg_radix  = radix_t'(data[0]);
            REG_DIGIT_COUNT: cfg_digits = data[3:0];
            REG_FILL_CHAR:   cfg_fill   = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_format(input radix_t radix, input logic [3:0] digits,
                              input logic [7:0] fill);
        write_reg(REG_RADIX_MODE, 32'(radix));
        write_reg(REG_DIGIT_COUNT, 32'(digits));
        write_reg(REG_FILL_CHAR, 32'(fill));
    endtask

    // Sample on the falling edge so the clocked processes have settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_values.size() != 0 || s_valid || expected_chars.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom >> $urandom_range(1, 31);
            2:       return $urandom_range(0, 20);
            default: return $urandom & 32'h0000_FFFF;
        endcase
    endfunction

    // Sender: present queued values, with random gaps between transactions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_value  <= '0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                render_value(s_value);
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_values.size() != 0) begin
                    s_valid <= 1'b1;
                    s_value <= pending_values.pop_front();
                    if (gaps_on && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(1, 14);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            take_gap  <= 0;
            hold_left <= 0;
        end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (take_gap != 0) begin
            take_gap <= take_gap - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                take_gap <= $urandom_range(1, 14);
            end
        end
    end

    always @(posedge aclk) begin : char_check
        char_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("character with none expected", 32'(m_char_code), 32'h0);
            end else begin
                want = expected_chars.pop_front();
                if (m_char_code !== want.code) begin
                    report_mismatch("char_code", 32'(m_char_code), 32'(want.code));
                end
                if (m_last_char !== want.last) begin
                    report_mismatch("last_char", 32'(m_last_char), 32'(want.last));
                end
                if (m_bad_width !== want.bad) begin
                    report_mismatch("bad_width", 32'(m_bad_width), 32'(want.bad));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        radix_t     radix;
        logic [3:0] digits;
        logic [7:0] fill;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset format: decimal, ten digits, space fill
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(32'd1000000000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        wait_drained();

        // full-width hex with '0' as the fill
        set_format(RADIX_HEX, 4'd8, CHAR_ZERO);
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'hDEAD_BEEF);
        pending_values.push_back(32'h0000_A000);
        wait_drained();

        // single decimal digit, top fill code
        set_format(RADIX_DEC, 4'd1, 8'hFF);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd7);
        pending_values.push_back(32'd123);
        wait_drained();

        set_format(RADIX_HEX, 4'd1, 8'h00);
        pending_values.push_back(32'h0000_000F);
        pending_values.push_back(32'h0000_0010);
        wait_drained();

        // widths that do not suit the radix
        set_format(RADIX_DEC, 4'd11, 8'h20);
        pending_values.push_back(32'd5);
        wait_drained();
        set_format(RADIX_DEC, 4'd0, 8'h20);
        pending_values.push_back(32'd0);
        wait_drained();
        set_format(RADIX_DEC, 4'd15, 8'h2A);
        pending_values.push_back(32'd42);
        wait_drained();
        set_format(RADIX_HEX, 4'd9, 8'h20);
        pending_values.push_back(32'd1);
        wait_drained();
        set_format(RADIX_HEX, 4'd15, 8'h20);
        pending_values.push_back(32'hFFFF_FFFF);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            radix = radix_t'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0) begin
                digits = 4'($urandom_range(0, 15));
            end else begin
                digits = 4'($urandom_range(1, (radix == RADIX_HEX) ? 8 : 10));
            end
            fill = ($urandom_range(0, 3) == 0) ? CHAR_ZERO : 8'($urandom_range(0, 255));
            // run the last phase without any idling
            if (phase == 7) begin
                gaps_on = 1'b0;
            end
            set_format(radix, digits, fill);
            for (int k = 0; k < 30; k++) begin
                pending_values.push_back(random_value());
            end
            // back up the block while the sender keeps offering values
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            report_mismatch("characters never delivered", 32'(expected_chars.size()), 32'h0);
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ita_pkg.sv
sv/ita_dabble_stage.sv
sv/ita_serializer.sv
sv/int_to_ascii_digits.sv
bench/int_to_ascii_digits_tb.sv
